// ===== design/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared types and constants of the masked byte pattern scanner.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 32;
    localparam int OFFSET_BITS_DEF = 32;

    localparam int PATTERN_BYTES  = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int LEN_RAW_W      = 6;
    localparam int MATCH_OFFSET_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW      = 3'd0,
        CFG_PATTERN_MID_LOW  = 3'd1,
        CFG_PATTERN_MID_HIGH = 3'd2,
        CFG_PATTERN_HIGH     = 3'd3,
        CFG_CARE_MASK        = 3'd4,
        CFG_PATTERN_LENGTH   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_scan_word;

    typedef struct packed {
        logic                      found;
        logic [MATCH_OFFSET_W-1:0] match_offset;
    } t_result_word;

    typedef struct packed {
        logic [PATTERN_BYTES-1:0][7:0] pattern;
        logic [PATTERN_BYTES-1:0]      care;
        logic [LEN_RAW_W-1:0]          length_raw;
    } t_pattern_cfg;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_status;

endpackage

// ===== design/mbps_stream_if.sv =====
// ----------------------------------------------------------------------------
// mbps_stream_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface mbps_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/mbps_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mbps_cfg_regs
// Configuration registers: pattern bytes, care mask and pattern length.
// ----------------------------------------------------------------------------
module mbps_cfg_regs import mbps_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_pattern_cfg          o_cfg
);

    logic [3:0][CFG_DATA_W-1:0] r_pattern_words;
    logic [PATTERN_BYTES-1:0]   r_care;
    logic [LEN_RAW_W-1:0]       r_length;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_words <= '0;
            r_care          <= '0;
            r_length        <= LEN_RAW_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN_LOW:      r_pattern_words[0] <= i_cfg_data;
                CFG_PATTERN_MID_LOW:  r_pattern_words[1] <= i_cfg_data;
                CFG_PATTERN_MID_HIGH: r_pattern_words[2] <= i_cfg_data;
                CFG_PATTERN_HIGH:     r_pattern_words[3] <= i_cfg_data;
                CFG_CARE_MASK:        r_care   <= i_cfg_data[PATTERN_BYTES-1:0];
                CFG_PATTERN_LENGTH:   r_length <= i_cfg_data[LEN_RAW_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    // byte 0 sits in the low bits of the low word
    assign o_cfg.pattern    = r_pattern_words;
    assign o_cfg.care       = r_care;
    assign o_cfg.length_raw = r_length;

endmodule

// ===== design/mbps_window.sv =====
// ----------------------------------------------------------------------------
// mbps_window
// Sliding byte window, saturating byte count and evaluation stage flags.
// ----------------------------------------------------------------------------
module mbps_window import mbps_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_advance,
    input  t_scan_word                    i_word,
    output logic [PATTERN_MAX-1:0][7:0]   o_window,
    output logic [OFFSET_BITS-1:0]        o_count,
    output t_stage_status                 o_status
);

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    logic [PATTERN_MAX-1:0][7:0] r_window;
    logic [PATTERN_MAX-1:0][7:0] n_window;
    logic [OFFSET_BITS-1:0]      r_count;
    logic [OFFSET_BITS-1:0]      n_count;
    logic                        r_valid;
    logic                        n_valid;
    logic                        r_last;

    // a region's last word leaves the window and count to be restarted by the next word
    always_comb begin
        n_window[0] = i_word.data_byte;
        for (int i = 1; i < PATTERN_MAX; i++) begin
            n_window[i] = r_last ? 8'h00 : r_window[i-1];
        end
        if (r_last) begin
            n_count = OFFSET_BITS'(1);
        end else if (r_count == COUNT_MAX) begin
            n_count = r_count;
        end else begin
            n_count = r_count + OFFSET_BITS'(1);
        end
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_load) begin
                r_window <= n_window;
                r_count  <= n_count;
                r_last   <= i_word.last_byte;
            end
        end
    end

    assign o_window       = r_window;
    assign o_count        = r_count;
    assign o_status.valid = r_valid;
    assign o_status.last  = r_last;

endmodule

// ===== design/mbps_match.sv =====
// ----------------------------------------------------------------------------
// mbps_match
// Parallel masked compare of the window against the pattern, plus offset.
// ----------------------------------------------------------------------------
module mbps_match import mbps_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  t_pattern_cfg                  i_cfg,
    input  logic [PATTERN_MAX-1:0][7:0]   i_window,
    input  logic [OFFSET_BITS-1:0]        i_count,
    output logic                          o_hit,
    output logic [MATCH_OFFSET_W-1:0]     o_offset
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam logic [LEN_RAW_W-1:0] LEN_LIMIT = LEN_RAW_W'(PATTERN_MAX);

    logic [LEN_W-1:0]                      act_len;
    logic [PATTERN_MAX-1:0][LEN_RAW_W-1:0] pat_idx;
    logic [PATTERN_MAX-1:0]                pos_ok;
    logic [OFFSET_BITS-1:0]                diff;
    logic [OFFSET_BITS+MATCH_OFFSET_W-1:0] diff_ext;

    // zero length acts as one, oversize clamps to the window depth
    always_comb begin
        if (i_cfg.length_raw == '0) begin
            act_len = LEN_W'(1);
        end else if (i_cfg.length_raw > LEN_LIMIT) begin
            act_len = LEN_W'(PATTERN_MAX);
        end else begin
            act_len = i_cfg.length_raw[LEN_W-1:0];
        end
    end

    // window entry j (newest at 0) lines up with pattern byte len-1-j
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            pat_idx[j] = LEN_RAW_W'(act_len) - LEN_RAW_W'(j) - LEN_RAW_W'(1);
            pos_ok[j]  = (LEN_W'(j) >= act_len)
                || !i_cfg.care[pat_idx[j][4:0]]
                || (i_window[j] == i_cfg.pattern[pat_idx[j][4:0]]);
        end
    end

    assign o_hit    = (&pos_ok) && (i_count >= OFFSET_BITS'(act_len));
    assign diff     = i_count - OFFSET_BITS'(act_len);
    assign diff_ext = {{MATCH_OFFSET_W{1'b0}}, diff};
    assign o_offset = diff_ext[MATCH_OFFSET_W-1:0];

endmodule

// ===== design/masked_byte_pattern_scan_core.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_core
// Scans a byte stream for the first match of a pattern of up to 32 bytes with
// per-byte wildcards. Takes one byte per cycle unless the input stalls. A byte
// is shifted into the window register when accepted, compared in the following
// cycle, and any result is then loaded into the output register. The input
// stalls only when the output register still holds an untaken result and
// the byte under compare yields another one. One result per region: the first
// match with its start offset, or not-found at the region's last byte.
// Configuration must be written while the scanner idles; not enforced here.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_core import mbps_pkg::*; #(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mbps_stream_if.sink           i_scan,
    mbps_stream_if.source         o_result
);

    t_pattern_cfg                cfg;
    logic [PATTERN_MAX-1:0][7:0] window;
    logic [OFFSET_BITS-1:0]      count;
    t_stage_status               status;
    logic                        hit;
    logic [MATCH_OFFSET_W-1:0]   offset;

    logic         accept;
    logic         advance;
    logic         emit_hit;
    logic         emit_end;
    logic         produce;
    logic         out_free;
    logic         r_latched;
    logic         n_latched;
    logic         r_out_valid;
    t_result_word r_out_word;

    mbps_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    mbps_window #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (accept),
        .i_advance (advance),
        .i_word    (i_scan.payload),
        .o_window  (window),
        .o_count   (count),
        .o_status  (status)
    );

    mbps_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .OFFSET_BITS (OFFSET_BITS)
    ) u_match (
        .i_cfg    (cfg),
        .i_window (window),
        .i_count  (count),
        .o_hit    (hit),
        .o_offset (offset)
    );

    assign emit_hit = status.valid && !r_latched && hit;
    assign emit_end = status.valid && status.last && !r_latched && !hit;
    assign produce  = emit_hit || emit_end;
    assign out_free = !r_out_valid || o_result.ready;
    assign advance  = status.valid && (!produce || out_free);
    assign i_scan.ready = !status.valid || advance;
    assign accept   = i_scan.valid && i_scan.ready;

    // clear the latch with the region's last word
    always_comb begin
        if (advance) begin
            n_latched = status.last ? 1'b0 : (r_latched || hit);
        end else begin
            n_latched = r_latched;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_latched <= n_latched;
            if (advance && produce) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && produce) begin
            r_out_word.found        <= emit_hit;
            r_out_word.match_offset <= emit_hit ? offset : '0;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out_word;

    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(emit_hit && emit_end))
        else $error("hit and not-found raised for the same word");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && produce) |-> out_free)
        else $error("pending result overwritten");

    a_window_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (!status.valid || advance))
        else $error("window shifted before its word was compared");

    a_region_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && status.last) |=> !r_latched)
        else $error("match latch survived the end of a region");

endmodule

// ===== tb/sv/masked_byte_pattern_scan_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// masked_byte_pattern_scan_core_test
// Drives byte regions through the masked pattern scanner and checks the
// found / offset result of every region against a software copy of the scan.
// It starts with a short directed run, then moves through a series of
// pattern, mask and length settings, most with source or sink throttling.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scan_core_test;
    import mbps_pkg::*;

    localparam int RANDOM_WORDS = 1550;
    localparam int PHASES       = 12;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    class scan_scoreboard;
        logic [CFG_DATA_W-1:0]       pattern_words [4];
        logic [PATTERN_BYTES-1:0]    care;
        logic [LEN_RAW_W-1:0]        length_raw;
        logic [7:0]                  window [PATTERN_BYTES];
        logic [OFFSET_BITS_DEF-1:0]  bytes_seen;
        bit                          latched;
        t_result_word                pending_results [$];
        int                          errors;
        int                          results_checked;

        function new();
            foreach (pattern_words[i]) pattern_words[i] = '0;
            care            = '0;
            length_raw      = 1;
            errors          = 0;
            results_checked = 0;
            clear_region();
        endfunction

        function void clear_region();
            foreach (window[i]) window[i] = 8'h00;
            bytes_seen = '0;
            latched    = 1'b0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_PATTERN_LOW:      pattern_words[0] = data;
                CFG_PATTERN_MID_LOW:  pattern_words[1] = data;
                CFG_PATTERN_MID_HIGH: pattern_words[2] = data;
                CFG_PATTERN_HIGH:     pattern_words[3] = data;
                CFG_CARE_MASK:        care = data[PATTERN_BYTES-1:0];
                CFG_PATTERN_LENGTH:   length_raw = data[LEN_RAW_W-1:0];
                default: ;
            endcase
        endfunction

        // zero acts as one, anything past the window acts as a full window
        function int active_length();
            if (length_raw == 0) return 1;
            if (length_raw > PATTERN_MAX_DEF) return PATTERN_MAX_DEF;
            return int'(length_raw);
        endfunction

        function logic [7:0] pattern_byte(int k);
            return pattern_words[k / 8][(k % 8) * 8 +: 8];
        endfunction

        // pattern byte 0 lines up with the oldest of the last len bytes in the window
        function bit window_hit(int len);
            for (int k = 0; k < len; k++)
                if (care[k] && pattern_byte(k) != window[len-1-k]) return 1'b0;
            return 1'b1;
        endfunction

        function void note_byte(t_scan_word w);
            int           len;
            t_result_word r;
            len = active_length();
            for (int i = PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = w.data_byte;
            if (bytes_seen != '1) bytes_seen++;
            if (!latched && bytes_seen >= len && window_hit(len)) begin
                latched        = 1'b1;
                r.found        = 1'b1;
                r.match_offset = MATCH_OFFSET_W'(bytes_seen - len);
                pending_results.push_back(r);
            end
            if (w.last_byte) begin
                if (!latched) begin
                    r.found        = 1'b0;
                    r.match_offset = '0;
                    pending_results.push_back(r);
                end
                clear_region();
            end
        endfunction

        function void report_error(string what, t_result_word want, t_result_word got);
            errors++;
            if (errors <= 10)
                $display("%s: expected found=%0b offset=%0d, got found=%0b offset=%0d",
                         what, want.found, want.match_offset, got.found, got.match_offset);
        endfunction

        function void check_result(t_result_word got);
            t_result_word want;
            results_checked++;
            if (pending_results.size() == 0) begin
                report_error("result with none pending", 'x, got);
                return;
            end
            want = pending_results.pop_front();
            if (got.found !== want.found || got.match_offset !== want.match_offset)
                report_error("result mismatch", want, got);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mbps_stream_if #(.t_payload(t_scan_word))   scan_if ();
    mbps_stream_if #(.t_payload(t_result_word)) result_if ();

    scan_scoreboard board = new();

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int cycles         = 0;
    int words_sent     = 0;
    int settings_used  = 0;

    masked_byte_pattern_scan_core i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_scan     (scan_if),
        .o_result   (result_if)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("masked_byte_pattern_scan_core_test: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready)
            board.check_result(result_if.payload);
        result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic logic [7:0] random_byte();
        // mix in pattern bytes so chance matches turn up in the filler too
        if ($urandom_range(1) == 1) return 8'($urandom);
        return board.pattern_byte($urandom_range(PATTERN_BYTES - 1));
    endfunction

    task automatic send_word(logic [7:0] data, logic last);
        t_scan_word w;
        w.data_byte = data;
        w.last_byte = last;
        while ($urandom_range(99) < src_idle_pct) begin
            scan_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        scan_if.valid   <= 1'b1;
        scan_if.payload <= w;
        do @(posedge i_clk); while (!scan_if.ready);
        board.note_byte(w);
        words_sent++;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.write_reg(idx, data);
    endtask

    // drain the scanner, then rewrite every register; junk above the
    // register width must be dropped
    task automatic apply_setting(logic [63:0] w0, logic [63:0] w1, logic [63:0] w2,
                                 logic [63:0] w3, logic [31:0] care_bits,
                                 logic [5:0] len_raw);
        scan_if.valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(CFG_PATTERN_LOW, w0);
        write_reg(CFG_PATTERN_MID_LOW, w1);
        write_reg(CFG_PATTERN_MID_HIGH, w2);
        write_reg(CFG_PATTERN_HIGH, w3);
        write_reg(CFG_CARE_MASK, {$urandom, care_bits});
        write_reg(CFG_PATTERN_LENGTH, {58'({$urandom, $urandom}), len_raw});
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic pick_setting(int phase);
        logic [63:0] w [4];
        logic [31:0] care_bits;
        logic [5:0]  len_raw;
        int          pick;
        foreach (w[i]) w[i] = {$urandom, $urandom};
        pick = $urandom_range(3);
        care_bits = (pick == 0) ? 32'hFFFF_FFFF :
                    (pick == 1) ? $urandom :
                    (pick == 2) ? ($urandom | $urandom) : ($urandom & $urandom);
        pick = $urandom_range(9);
        len_raw = (pick < 6) ? 6'($urandom_range(2, 8)) :
                  (pick < 8) ? 6'($urandom_range(9, 31)) : 6'($urandom_range(33, 63));
        case (phase)
            0: begin
                len_raw   = 6'd32;
                care_bits = '1;
            end
            1: begin
                len_raw   = 6'd1;
                care_bits = '1;
            end
            2: len_raw = 6'd0;
            3: begin
                len_raw   = 6'd63;
                care_bits = '0;
            end
            4: begin
                len_raw   = 6'd33;
                care_bits = '1;
                foreach (w[i]) w[i] = '0;
            end
            5: foreach (w[i]) w[i] = '1;
            default: ;
        endcase
        apply_setting(w[0], w[1], w[2], w[3], care_bits, len_raw);
    endtask

    task automatic send_region();
        int         len;
        int         kind;
        int         prefix;
        int         suffix;
        int         cut;
        int         n;
        logic [7:0] b;
        len  = board.active_length();
        kind = $urandom_range(99);
        if (kind < 60) begin
            // filler, the pattern with random wildcard bytes, optional tail
            prefix = $urandom_range(10);
            suffix = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (prefix) send_word(random_byte(), 1'b0);
            for (int k = 0; k < len; k++) begin
                b = board.care[k] ? board.pattern_byte(k) : random_byte();
                send_word(b, (suffix == 0) && (k == len - 1));
            end
            for (int s = 0; s < suffix; s++) send_word(random_byte(), s == suffix - 1);
        end else if (kind < 75) begin
            // pattern with one flipped bit, region ends right after it
            cut = $urandom_range(len - 1);
            for (int k = 0; k < len; k++) begin
                b = board.care[k] ? board.pattern_byte(k) : random_byte();
                if (k == cut) b = b ^ (8'd1 << $urandom_range(7));
                send_word(b, k == len - 1);
            end
        end else if (kind < 88) begin
            n = (len > 1) ? $urandom_range(1, len - 1) : 1;
            for (int i = 0; i < n; i++) send_word(random_byte(), i == n - 1);
        end else begin
            n = $urandom_range(1, 24);
            for (int i = 0; i < n; i++) send_word(8'($urandom), i == n - 1);
        end
    endtask

    initial begin
        int target;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= CFG_PATTERN_LOW;
        i_cfg_data      <= '0;
        scan_if.valid   <= 1'b0;
        scan_if.payload <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setting: one byte, all wildcard, so the first byte matches
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        // zero length acts as one byte
        apply_setting(64'hA5, '0, '0, '0, '1, 6'd0);
        send_word(8'h00, 1'b1);
        send_word(8'h11, 1'b0);
        send_word(8'hA5, 1'b1);
        // oversize length, region shorter than the window
        apply_setting({$urandom, $urandom}, '1, '0, {$urandom, $urandom}, '0, 6'd63);
        send_word(8'h5A, 1'b0);
        send_word(8'h5A, 1'b0);
        send_word(8'h3C, 1'b1);
        // match mid region, later bytes ignored
        apply_setting(64'h00FF, '0, '0, '0, '1, 6'd2);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b1);

        for (int phase = 0; phase < PHASES; phase++) begin
            pick_setting(phase);
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 55; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 55; end
                default: begin src_idle_pct = 21; sink_stall_pct = 21; end
            endcase
            target = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < target) send_region();
        end

        scan_if.valid <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        foreach (board.pending_results[i])
            board.report_error("result never arrived", board.pending_results[i], 'x);

        $display("Scanned %0d words over %0d pattern settings and four throttle modes,",
                 words_sent, settings_used);
        $display("checked %0d region results, %0d failures.", board.results_checked,
                 board.errors);
        if (board.errors == 0) begin
            $display("masked_byte_pattern_scan_core_test: clean");
        end else begin
            $display("masked_byte_pattern_scan_core_test: errors");
        end
        $finish;
    end

endmodule
